// ===== rtl/aavg_pkg.sv =====
// shared types and constants for the adc average and voltage guard block
// register map, register file struct, guard flag struct; no dependencies
package aavg_pkg;

  // fixed register widths
  localparam int REG_W      = 12;
  localparam int TIME_W     = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  typedef logic [REG_W-1:0]  reg_val_t;
  typedef logic [TIME_W-1:0] time_val_t;

  // register index, byte address is four times this
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLTAGE_OFFSET     = 3'd0,
    REG_RETURN_OFFSET      = 3'd1,
    REG_PHASE_U_OFFSET     = 3'd2,
    REG_PHASE_V_OFFSET     = 3'd3,
    REG_HIGH_VOLTAGE_LIMIT = 3'd4,
    REG_LOW_VOLTAGE_LIMIT  = 3'd5,
    REG_OVER_TIME          = 3'd6,
    REG_UNDER_TIME         = 3'd7
  } cfg_reg_t;

  // register file contents
  typedef struct packed {
    reg_val_t  voltage_offset;
    reg_val_t  return_offset;
    reg_val_t  phase_u_offset;
    reg_val_t  phase_v_offset;
    reg_val_t  high_voltage_limit;
    reg_val_t  low_voltage_limit;
    time_val_t over_time;
    time_val_t under_time;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    voltage_offset:     12'd257,
    return_offset:      12'd0,
    phase_u_offset:     12'd0,
    phase_v_offset:     12'd0,
    high_voltage_limit: 12'd2000,
    low_voltage_limit:  12'd1000,
    over_time:          16'd1000,
    under_time:         16'd100
  };

  // trip flags from the guard
  typedef struct packed {
    logic under_voltage;
    logic over_voltage;
  } guard_flags_t;

endpackage

// ===== rtl/aavg_cfg_regs.sv =====
// apb-style register file holding offsets, voltage limits and trip times
// depends on aavg_pkg for the register map and register struct
module aavg_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [aavg_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [aavg_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [aavg_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output aavg_pkg::cfg_regs_t               regs
);

  aavg_pkg::cfg_regs_t regs_r;
  aavg_pkg::cfg_regs_t regs_nxt;
  aavg_pkg::cfg_reg_t  reg_idx;
  logic                wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = aavg_pkg::cfg_reg_t'(cfg_paddr[aavg_pkg::CFG_ADDR_W-1:2]);
  assign regs       = regs_r;

  // register write decode
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (reg_idx)
        aavg_pkg::REG_VOLTAGE_OFFSET:
          regs_nxt.voltage_offset = cfg_pwdata[aavg_pkg::REG_W-1:0];
        aavg_pkg::REG_RETURN_OFFSET:
          regs_nxt.return_offset = cfg_pwdata[aavg_pkg::REG_W-1:0];
        aavg_pkg::REG_PHASE_U_OFFSET:
          regs_nxt.phase_u_offset = cfg_pwdata[aavg_pkg::REG_W-1:0];
        aavg_pkg::REG_PHASE_V_OFFSET:
          regs_nxt.phase_v_offset = cfg_pwdata[aavg_pkg::REG_W-1:0];
        aavg_pkg::REG_HIGH_VOLTAGE_LIMIT:
          regs_nxt.high_voltage_limit = cfg_pwdata[aavg_pkg::REG_W-1:0];
        aavg_pkg::REG_LOW_VOLTAGE_LIMIT:
          regs_nxt.low_voltage_limit = cfg_pwdata[aavg_pkg::REG_W-1:0];
        aavg_pkg::REG_OVER_TIME:
          regs_nxt.over_time = cfg_pwdata[aavg_pkg::TIME_W-1:0];
        aavg_pkg::REG_UNDER_TIME:
          regs_nxt.under_time = cfg_pwdata[aavg_pkg::TIME_W-1:0];
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= aavg_pkg::CFG_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      aavg_pkg::REG_VOLTAGE_OFFSET:
        cfg_prdata = aavg_pkg::CFG_DATA_W'(regs_r.voltage_offset);
      aavg_pkg::REG_RETURN_OFFSET:
        cfg_prdata = aavg_pkg::CFG_DATA_W'(regs_r.return_offset);
      aavg_pkg::REG_PHASE_U_OFFSET:
        cfg_prdata = aavg_pkg::CFG_DATA_W'(regs_r.phase_u_offset);
      aavg_pkg::REG_PHASE_V_OFFSET:
        cfg_prdata = aavg_pkg::CFG_DATA_W'(regs_r.phase_v_offset);
      aavg_pkg::REG_HIGH_VOLTAGE_LIMIT:
        cfg_prdata = aavg_pkg::CFG_DATA_W'(regs_r.high_voltage_limit);
      aavg_pkg::REG_LOW_VOLTAGE_LIMIT:
        cfg_prdata = aavg_pkg::CFG_DATA_W'(regs_r.low_voltage_limit);
      aavg_pkg::REG_OVER_TIME:
        cfg_prdata = aavg_pkg::CFG_DATA_W'(regs_r.over_time);
      aavg_pkg::REG_UNDER_TIME:
        cfg_prdata = aavg_pkg::CFG_DATA_W'(regs_r.under_time);
      default: cfg_prdata = '0;
    endcase
  end

endmodule

// ===== rtl/aavg_channel.sv =====
// one channel: offset removal, tap history with running sum, zero clamp
// depends on aavg_pkg for the offset register type
module aavg_channel #(
  parameter int AVERAGE_TAPS = 4,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              en,
  input  logic [SAMPLE_BITS-1:0]                            sample,
  input  aavg_pkg::reg_val_t                                offset,
  output logic [SAMPLE_BITS+$clog2(AVERAGE_TAPS)-1:0]       avg
);

  localparam int AVG_W  = SAMPLE_BITS + $clog2(AVERAGE_TAPS);
  localparam int DIFF_W = ((SAMPLE_BITS > aavg_pkg::REG_W) ? SAMPLE_BITS
                                                            : aavg_pkg::REG_W) + 1;
  localparam int SUM_W  = DIFF_W + $clog2(AVERAGE_TAPS);
  localparam logic [SUM_W-1:0] TAPS_K = SUM_W'(AVERAGE_TAPS);

  logic signed [DIFF_W-1:0] line_r [AVERAGE_TAPS];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SUM_W-1:0]  off_scaled;

  // signed difference of sample and offset
  assign diff = $signed(DIFF_W'(sample) - DIFF_W'(offset));

  // running sum: add newest, drop the one leaving the line
  assign sum_nxt = sum_r + SUM_W'(diff) - SUM_W'(line_r[AVERAGE_TAPS-1]);

  // clamp to zero below offset times taps
  assign off_scaled = $signed(SUM_W'(offset) * TAPS_K);
  assign avg        = (sum_nxt < off_scaled) ? '0 : AVG_W'(sum_nxt);

  // history line and sum update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < AVERAGE_TAPS; k++) begin
        line_r[k] <= '0;
      end
      sum_r <= '0;
    end else if (en) begin
      line_r[0] <= diff;
      for (int k = 1; k < AVERAGE_TAPS; k++) begin
        line_r[k] <= line_r[k-1];
      end
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== rtl/aavg_guard.sv =====
// over- and under-voltage up/down counters with trip flags
// depends on aavg_pkg for the register struct and flag struct
module aavg_guard #(
  parameter int AVERAGE_TAPS = 4,
  parameter int AVG_W        = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [AVG_W-1:0]       voltage_avg,
  input  aavg_pkg::cfg_regs_t    cfg,
  output aavg_pkg::guard_flags_t flags
);

  localparam int LIM_W = aavg_pkg::REG_W + $clog2(AVERAGE_TAPS);
  localparam int CMP_W = (AVG_W > LIM_W) ? AVG_W : LIM_W;
  localparam logic [CMP_W-1:0] TAPS_K = CMP_W'(AVERAGE_TAPS);

  aavg_pkg::time_val_t over_count_r;
  aavg_pkg::time_val_t over_count_nxt;
  aavg_pkg::time_val_t under_count_r;
  aavg_pkg::time_val_t under_count_nxt;
  logic [CMP_W-1:0]    high_scaled;
  logic [CMP_W-1:0]    low_scaled;
  logic                over_up;
  logic                under_up;

  // saturating up/down step
  function automatic aavg_pkg::time_val_t count_step(aavg_pkg::time_val_t cnt,
                                                     logic up);
    aavg_pkg::time_val_t res;
    if (up) begin
      res = (cnt == '1) ? cnt : cnt + 1'b1;
    end else begin
      res = (cnt == '0) ? cnt : cnt - 1'b1;
    end
    return res;
  endfunction

  // limits scaled to sum units
  assign high_scaled = CMP_W'(cfg.high_voltage_limit) * TAPS_K;
  assign low_scaled  = CMP_W'(cfg.low_voltage_limit) * TAPS_K;
  assign over_up     = CMP_W'(voltage_avg) > high_scaled;
  assign under_up    = CMP_W'(voltage_avg) <= low_scaled;

  assign over_count_nxt  = count_step(over_count_r, over_up);
  assign under_count_nxt = count_step(under_count_r, under_up);

  // flags follow the updated counts
  assign flags.over_voltage  = over_count_nxt >= cfg.over_time;
  assign flags.under_voltage = under_count_nxt > cfg.under_time;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      over_count_r  <= '0;
      under_count_r <= '0;
    end else if (en) begin
      over_count_r  <= over_count_nxt;
      under_count_r <= under_count_nxt;
    end
  end

  // counters only move on an item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(over_count_r) && $stable(under_count_r))
    else $error("guard counters moved without an item");

  // counters step by at most one
  a_over_step: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> (over_count_r == $past(over_count_r))
        || (over_count_r == aavg_pkg::TIME_W'($past(over_count_r) + 1'b1))
        || (over_count_r == aavg_pkg::TIME_W'($past(over_count_r) - 1'b1)))
    else $error("over counter jumped");

  a_under_step: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> (under_count_r == $past(under_count_r))
        || (under_count_r == aavg_pkg::TIME_W'($past(under_count_r) + 1'b1))
        || (under_count_r == aavg_pkg::TIME_W'($past(under_count_r) - 1'b1)))
    else $error("under counter jumped");

endmodule

// ===== rtl/adc_average_voltage_guard_core.sv =====
// path: an accepted item passes the input register, then the result register, which drives out_tvalid
// throughput: one item per cycle while out_tready is high; the filter sums and guard counters update in one pass
// backpressure: a stalled result holds in the result register while one more item waits
// reset (rst_n low, synchronous): histories, sums and counters clear to zero,
// registers return to their defaults, both pipeline registers empty
module adc_average_voltage_guard_core #(
  parameter int AVERAGE_TAPS = 4,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // voltage_sample, return_sample, phase_u_sample, phase_v_sample from bit 0
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // voltage_average, return_average, phase_u_average, phase_v_average,
  // over_voltage, under_voltage from bit 0
  output logic [((4*(SAMPLE_BITS+$clog2(AVERAGE_TAPS))+2+7)/8)*8-1:0] out_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [aavg_pkg::CFG_ADDR_W-1:0]         cfg_paddr,
  input  logic [aavg_pkg::CFG_DATA_W-1:0]         cfg_pwdata,
  output logic [aavg_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int CHANNELS   = 4;
  localparam int AVG_W      = SAMPLE_BITS + $clog2(AVERAGE_TAPS);
  localparam int IN_W       = CHANNELS * SAMPLE_BITS;
  localparam int OUT_W      = CHANNELS * AVG_W + 2;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  aavg_pkg::cfg_regs_t    regs;
  aavg_pkg::guard_flags_t flags;
  aavg_pkg::reg_val_t     ch_offset [CHANNELS];
  logic [AVG_W-1:0]       ch_avg    [CHANNELS];

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [IN_W-1:0]  s1_data_r;
  logic [IN_W-1:0]  s1_data_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] out_data_nxt;
  logic             in_accept;
  logic             advance;

  // register file
  aavg_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .regs        (regs)
  );

  // handshake: input register moves into result register when it is free
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign s1_data_nxt   = in_accept ? in_tdata[IN_W-1:0] : s1_data_r;
  assign out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // per-channel offsets
  assign ch_offset[0] = regs.voltage_offset;
  assign ch_offset[1] = regs.return_offset;
  assign ch_offset[2] = regs.phase_u_offset;
  assign ch_offset[3] = regs.phase_v_offset;

  // filter channels
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    aavg_channel #(
      .AVERAGE_TAPS (AVERAGE_TAPS),
      .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_chan (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (advance),
      .sample (s1_data_r[c*SAMPLE_BITS +: SAMPLE_BITS]),
      .offset (ch_offset[c]),
      .avg    (ch_avg[c])
    );
  end

  // voltage trip counters
  aavg_guard #(
    .AVERAGE_TAPS (AVERAGE_TAPS),
    .AVG_W        (AVG_W)
  ) u_guard (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .voltage_avg (ch_avg[0]),
    .cfg         (regs),
    .flags       (flags)
  );

  // result packing
  assign out_data_nxt = advance ? {flags.under_voltage, flags.over_voltage,
                                   ch_avg[3], ch_avg[2], ch_avg[1], ch_avg[0]}
                                : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

  // a waiting item is neither lost nor altered while the result side stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_data_r))
    else $error("waiting input item lost");

endmodule

// ===== bench/tb.sv =====
// testbench for adc_average_voltage_guard_core: four-tap channel averages and voltage trip flags
// keeps its own model of the filter and trip counters and checks every output item against it
// depends on rtl/aavg_pkg.sv and rtl/adc_average_voltage_guard_core.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAPS        = 4;
  localparam int COUNT_ITEMS = 24;

  // one set of raw converter samples, voltage in the lowest bits
  typedef struct packed {
    logic [11:0] phase_v_sample;
    logic [11:0] phase_u_sample;
    logic [11:0] return_sample;
    logic [11:0] voltage_sample;
  } sample_set_t;

  // one output item, voltage average in the lowest bits
  typedef struct packed {
    logic [5:0]  pad;
    logic        under_voltage;
    logic        over_voltage;
    logic [13:0] phase_v_average;
    logic [13:0] phase_u_average;
    logic [13:0] return_average;
    logic [13:0] voltage_average;
  } avg_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  // voltage_sample, return_sample, phase_u_sample, phase_v_sample from bit 0
  logic [47:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // voltage_average, return_average, phase_u_average, phase_v_average,
  // over_voltage, under_voltage from bit 0
  logic [63:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [aavg_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [aavg_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [aavg_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // model state: register copy, history lines, trip counters
  aavg_pkg::cfg_regs_t guard_cfg = aavg_pkg::CFG_RESET;
  logic signed [12:0]  sample_line [4][TAPS];
  logic [15:0]         over_count = '0;
  logic [15:0]         under_count = '0;
  avg_result_t         expected_averages [$];

  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_hold = 0;

  adc_average_voltage_guard_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** adc_average_voltage_guard_core: FAILED **");
      $finish;
    end
  end

  // receiver: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      out_tready <= 1'b0;
      stall_hold--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // shift one sample set into the history lines, update the trip counters
  function automatic avg_result_t filter_and_guard(sample_set_t s);
    logic [11:0]        raw [4];
    aavg_pkg::reg_val_t offs [4];
    int                 sum;
    int                 avg [4];
    avg_result_t        r;
    raw  = '{s.voltage_sample, s.return_sample, s.phase_u_sample, s.phase_v_sample};
    offs = '{guard_cfg.voltage_offset, guard_cfg.return_offset,
             guard_cfg.phase_u_offset, guard_cfg.phase_v_offset};
    for (int c = 0; c < 4; c++) begin
      for (int k = TAPS - 1; k > 0; k--) sample_line[c][k] = sample_line[c][k-1];
      sample_line[c][0] = 13'(int'(raw[c]) - int'(offs[c]));
      sum = 0;
      for (int k = 0; k < TAPS; k++) sum += sample_line[c][k];
      // below the offset level, negative sums included, reads as zero
      avg[c] = (sum < int'(offs[c]) * TAPS) ? 0 : sum;
    end
    // saturating up/down counters on the clamped voltage average
    if (avg[0] > int'(guard_cfg.high_voltage_limit) * TAPS) begin
      if (over_count != 16'hFFFF) over_count++;
    end else if (over_count != 0) begin
      over_count--;
    end
    if (avg[0] <= int'(guard_cfg.low_voltage_limit) * TAPS) begin
      if (under_count != 16'hFFFF) under_count++;
    end else if (under_count != 0) begin
      under_count--;
    end
    r = '0;
    r.voltage_average = 14'(avg[0]);
    r.return_average  = 14'(avg[1]);
    r.phase_u_average = 14'(avg[2]);
    r.phase_v_average = 14'(avg[3]);
    r.over_voltage    = (over_count >= guard_cfg.over_time);
    r.under_voltage   = (under_count > guard_cfg.under_time);
    return r;
  endfunction

  function automatic logic [31:0] reg_value(aavg_pkg::cfg_reg_t idx);
    case (idx)
      aavg_pkg::REG_VOLTAGE_OFFSET:     return 32'(guard_cfg.voltage_offset);
      aavg_pkg::REG_RETURN_OFFSET:      return 32'(guard_cfg.return_offset);
      aavg_pkg::REG_PHASE_U_OFFSET:     return 32'(guard_cfg.phase_u_offset);
      aavg_pkg::REG_PHASE_V_OFFSET:     return 32'(guard_cfg.phase_v_offset);
      aavg_pkg::REG_HIGH_VOLTAGE_LIMIT: return 32'(guard_cfg.high_voltage_limit);
      aavg_pkg::REG_LOW_VOLTAGE_LIMIT:  return 32'(guard_cfg.low_voltage_limit);
      aavg_pkg::REG_OVER_TIME:          return 32'(guard_cfg.over_time);
      default:                          return 32'(guard_cfg.under_time);
    endcase
  endfunction

  // output check against the oldest expected item
  always @(posedge clk) begin : result_check
    avg_result_t got;
    avg_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_averages.size() == 0) begin
        $error("output item with nothing expected: %h", got);
        fail_count++;
      end else begin
        want = expected_averages.pop_front();
        check_field("voltage_average", want.voltage_average, got.voltage_average);
        check_field("return_average", want.return_average, got.return_average);
        check_field("phase_u_average", want.phase_u_average, got.phase_u_average);
        check_field("phase_v_average", want.phase_v_average, got.phase_v_average);
        check_field("over_voltage", want.over_voltage, got.over_voltage);
        check_field("under_voltage", want.under_voltage, got.under_voltage);
      end
    end
  end

  // offer one item, idle first at the current rate, record its expectation on accept
  task automatic send_samples(sample_set_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    expected_averages.push_back(filter_and_guard(s));
  endtask

  task automatic send_fill(logic [11:0] v, logic [11:0] r, logic [11:0] u, logic [11:0] w);
    sample_set_t s;
    s = '{phase_v_sample: w, phase_u_sample: u, return_sample: r, voltage_sample: v};
    send_samples(s);
  endtask

  // stop offering, wait for every expected item, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(aavg_pkg::cfg_reg_t idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      aavg_pkg::REG_VOLTAGE_OFFSET:     guard_cfg.voltage_offset     = value[11:0];
      aavg_pkg::REG_RETURN_OFFSET:      guard_cfg.return_offset      = value[11:0];
      aavg_pkg::REG_PHASE_U_OFFSET:     guard_cfg.phase_u_offset     = value[11:0];
      aavg_pkg::REG_PHASE_V_OFFSET:     guard_cfg.phase_v_offset     = value[11:0];
      aavg_pkg::REG_HIGH_VOLTAGE_LIMIT: guard_cfg.high_voltage_limit = value[11:0];
      aavg_pkg::REG_LOW_VOLTAGE_LIMIT:  guard_cfg.low_voltage_limit  = value[11:0];
      aavg_pkg::REG_OVER_TIME:          guard_cfg.over_time          = value[15:0];
      default:                          guard_cfg.under_time         = value[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic check_registers();
    for (int i = 0; i < 8; i++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      cfg_paddr   <= {aavg_pkg::cfg_reg_t'(i), 2'b00};
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      check_field("prdata", reg_value(aavg_pkg::cfg_reg_t'(i)), cfg_prdata);
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      @(posedge clk);
    end
  endtask

  // edge values of the fields, offset clamp, negative sums, limit boundaries
  task automatic test_directed();
    check_registers();
    send_fill(12'd0, 12'd0, 12'd0, 12'd0);
    repeat (4) send_fill(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_fill(12'hAAA, 12'h555, 12'hAAA, 12'h555);
    send_fill(12'h555, 12'hAAA, 12'h555, 12'hAAA);
    send_fill(12'd257, 12'd1, 12'd4094, 12'd2048);
    settle();
    // offsets at full scale, limits that trip at once
    write_reg(aavg_pkg::REG_VOLTAGE_OFFSET, 32'hFFF);
    write_reg(aavg_pkg::REG_RETURN_OFFSET, 32'hFFF);
    write_reg(aavg_pkg::REG_PHASE_U_OFFSET, 32'hFFF);
    write_reg(aavg_pkg::REG_PHASE_V_OFFSET, 32'hFFF);
    write_reg(aavg_pkg::REG_HIGH_VOLTAGE_LIMIT, 32'h0);
    write_reg(aavg_pkg::REG_LOW_VOLTAGE_LIMIT, 32'hFFF);
    write_reg(aavg_pkg::REG_OVER_TIME, 32'h0);
    write_reg(aavg_pkg::REG_UNDER_TIME, 32'h0);
    check_registers();
    send_fill(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_fill(12'd0, 12'd0, 12'd0, 12'd0);
    repeat (2) send_fill(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    settle();
    // zero offsets, full-scale sum sits exactly on the high limit
    write_reg(aavg_pkg::REG_VOLTAGE_OFFSET, 32'h0);
    write_reg(aavg_pkg::REG_RETURN_OFFSET, 32'h0);
    write_reg(aavg_pkg::REG_PHASE_U_OFFSET, 32'h0);
    write_reg(aavg_pkg::REG_PHASE_V_OFFSET, 32'h0);
    write_reg(aavg_pkg::REG_HIGH_VOLTAGE_LIMIT, 32'hFFF);
    write_reg(aavg_pkg::REG_LOW_VOLTAGE_LIMIT, 32'h0);
    write_reg(aavg_pkg::REG_OVER_TIME, 32'hFFFF);
    write_reg(aavg_pkg::REG_UNDER_TIME, 32'hFFFF);
    check_registers();
    repeat (4) send_fill(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_fill(12'd0, 12'd0, 12'd0, 12'd0);
    settle();
  endtask

  // both counters driven across their time registers at full rate
  task automatic test_counter_limits();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // under counts up every item, flag must stay low with full-scale time
    write_reg(aavg_pkg::REG_VOLTAGE_OFFSET, 32'h0);
    write_reg(aavg_pkg::REG_HIGH_VOLTAGE_LIMIT, 32'hFFF);
    write_reg(aavg_pkg::REG_LOW_VOLTAGE_LIMIT, 32'hFFF);
    write_reg(aavg_pkg::REG_OVER_TIME, 32'h0);
    write_reg(aavg_pkg::REG_UNDER_TIME, 32'hFFFF);
    repeat (COUNT_ITEMS) send_samples(sample_set_t'({$urandom(), $urandom()}));
    settle();
    // short under time, flag rises once the count passes it
    write_reg(aavg_pkg::REG_UNDER_TIME, 32'd10);
    repeat (5) send_samples(sample_set_t'({$urandom(), $urandom()}));
    settle();
    // over counts up past its time while under drains back toward zero
    write_reg(aavg_pkg::REG_HIGH_VOLTAGE_LIMIT, 32'h0);
    write_reg(aavg_pkg::REG_LOW_VOLTAGE_LIMIT, 32'h0);
    write_reg(aavg_pkg::REG_OVER_TIME, 32'd12);
    repeat (COUNT_ITEMS) send_fill(12'hFFF, 12'($urandom()), 12'($urandom()), 12'($urandom()));
    settle();
  endtask

  function automatic logic [31:0] rand_level();
    case ($urandom_range(3))
      0:       return 32'h0;
      1:       return 32'hFFF;
      default: return 32'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(5))
      0:       return 32'h0;
      1:       return 32'hFFFF;
      2:       return 32'($urandom_range(65535));
      default: return 32'($urandom_range(40));
    endcase
  endfunction

  // random settings and samples, voltage held near a level for runs of items
  task automatic test_random_traffic();
    int          idle_by_phase [4];
    int          stall_by_phase [4];
    int          run_left;
    int          level;
    sample_set_t s;
    idle_by_phase  = '{0, 49, 0, 35};
    stall_by_phase = '{0, 0, 49, 35};
    run_left = 0;
    level    = 0;
    for (int p = 0; p < 4; p++) begin
      for (int round = 0; round < 2; round++) begin
        settle();
        send_idle_pct  = idle_by_phase[p];
        recv_stall_pct = stall_by_phase[p];
        // upper bits of the write data carry noise the block must drop
        write_reg(aavg_pkg::REG_VOLTAGE_OFFSET,
                  rand_level() | ($urandom() & 32'hFFFF_F000));
        write_reg(aavg_pkg::REG_RETURN_OFFSET,
                  rand_level() | ($urandom() & 32'hFFFF_F000));
        write_reg(aavg_pkg::REG_PHASE_U_OFFSET,
                  rand_level() | ($urandom() & 32'hFFFF_F000));
        write_reg(aavg_pkg::REG_PHASE_V_OFFSET,
                  rand_level() | ($urandom() & 32'hFFFF_F000));
        write_reg(aavg_pkg::REG_HIGH_VOLTAGE_LIMIT,
                  rand_level() | ($urandom() & 32'hFFFF_F000));
        write_reg(aavg_pkg::REG_LOW_VOLTAGE_LIMIT,
                  rand_level() | ($urandom() & 32'hFFFF_F000));
        write_reg(aavg_pkg::REG_OVER_TIME, rand_time() | ($urandom() & 32'hFFFF_0000));
        write_reg(aavg_pkg::REG_UNDER_TIME, rand_time() | ($urandom() & 32'hFFFF_0000));
        for (int n = 0; n < 175; n++) begin
          if (run_left == 0) begin
            run_left = $urandom_range(60, 5);
            level    = $urandom_range(4095);
          end
          run_left--;
          s = sample_set_t'({$urandom(), $urandom()});
          if ($urandom_range(4) != 0) begin
            s.voltage_sample = 12'(level + $urandom_range(64) > 4127 ? 4095 :
                                   (level + $urandom_range(64) < 32 ? 0 :
                                    level + $urandom_range(64) - 32));
          end
          send_samples(s);
        end
      end
    end
    settle();
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    stall_hold     = 300;
    repeat (30) send_samples(sample_set_t'({$urandom(), $urandom()}));
    settle();
  endtask

  initial begin
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < TAPS; k++) sample_line[c][k] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_counter_limits();
    test_random_traffic();
    test_output_backpressure();
    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** adc_average_voltage_guard_core: PASSED **");
    end else begin
      $display("** adc_average_voltage_guard_core: FAILED **");
    end
    $finish;
  end

endmodule
